@@ src/mlfq_pkg.sv @@
// shared types and constants for the multilevel feedback queue scheduler
package mlfq_pkg;

    localparam logic [2:0] FUNC_RESCHED   = 3'd0;
    localparam logic [2:0] FUNC_ADMIT     = 3'd1;
    localparam logic [2:0] FUNC_CHARGE    = 3'd2;
    localparam logic [2:0] FUNC_DEFER_ON  = 3'd3;
    localparam logic [2:0] FUNC_DEFER_OFF = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEFERRED = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    localparam int PID_W   = 5;
    localparam int LEVEL_W = 3;
    localparam int PRIO_W  = 15;
    localparam int TIME_W  = 16;

    localparam logic [7:0] DEFER_MAX = 8'd255;

    // one queue slot, carried along the chain
    typedef struct packed {
        logic              valid;
        logic [PID_W-1:0]  pid;
        logic              is_user;
        logic [LEVEL_W-1:0] level;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // per-cell command from the sequencer
    typedef struct packed {
        logic              shift;     // take from right neighbor at or after remove point
        logic [PID_W-1:0]  rm_pid;    // pid being removed
        logic              rm_en;
        logic              boost;     // set level of user entries to zero
    } t_cell_cmd;

endpackage

@@ src/mlfq_process_scheduler_top.sv @@
// top level of the multilevel feedback queue scheduler
//  channel | signals                      | direction
//  in      | i_valid/o_ready + fields     | word in
//  out     | o_valid/i_ready + fields     | word out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data | register write
// admit, charge, defer, error and deferred reschedule words: result valid in the
// cycle after accept; a defer-off that releases a deferred reschedule runs the
// reschedule path: a request state, a scan over all NPROCS slots, a take state
// that may first fold in a user or key-zero pick, and an output state, skipped when
// nothing is picked. a boost adds one walk of the queue per level below the top.
// reset is synchronous; it clears the state, counters and per-process attributes.
// a word is held in the output register until taken; the next word is
// accepted the cycle after that register is freed.
module mlfq_process_scheduler_top #(
    parameter int NPROCS = 32,
    parameter int LEVELS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_pid,
    input  logic        i_is_user,
    input  logic        i_fresh,
    input  logic [14:0] i_sys_priority,
    input  logic        i_current_runnable,
    input  logic        i_boost,
    input  logic [15:0] i_elapsed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_next_pid,
    output logic [15:0] o_slice,
    output logic        o_switched,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int IDX_W = (NPROCS > 1) ? $clog2(NPROCS) : 1;
    localparam int CNT_W = $clog2(NPROCS + 1);
    localparam logic [2:0] LV_LAST = 3'(LEVELS - 1);
    localparam logic [2:0] LV_NONE = 3'(LEVELS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REQ   = 3'd1;
    localparam logic [2:0] S_BOOST = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_TAKE  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_quantum;
    logic [15:0] r_allot;
    logic [4:0]  r_cur;
    logic [7:0]  r_defer;
    logic        r_attempt;
    logic        r_run, r_boost;

    // per-process attributes (flip-flops, reset to zero)
    logic [2:0]  r_plevel [NPROCS];
    logic [15:0] r_pused  [NPROCS];
    logic        r_puser  [NPROCS];
    logic        r_pq     [NPROCS];
    logic [CNT_W-1:0] r_cnt;

    // system keys per pid, kept to requeue the current process
    logic [14:0] r_pprio [NPROCS];

    // scan state
    logic [IDX_W-1:0] r_si;
    logic        r_sfound;
    logic [14:0] r_sbest;
    logic [4:0]  r_spid;
    logic [2:0]  r_ubest;
    logic [4:0]  r_upid;
    logic        r_kfound;
    logic [4:0]  r_kpid;

    logic        r_ov;
    logic [4:0]  r_onext;
    logic [15:0] r_oslice;
    logic        r_osw;
    logic [1:0]  r_ost;
    logic [1:0]  w_ost;

    // chain
    mlfq_pkg::t_entry w_ent [NPROCS+1];
    logic        w_rm [NPROCS+1];
    mlfq_pkg::t_cell_cmd w_cmd;
    logic        w_load_en;
    mlfq_pkg::t_entry w_load;
    logic [CNT_W-1:0] w_load_at;

    assign w_ent[NPROCS] = '0;
    assign w_rm[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NPROCS; g++) begin : g_cell
            mlfq_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
                .i_load(w_load_en && (w_load_at == CNT_W'(g))),
                .i_load_entry(w_load),
                .i_rm_left(w_rm[g]), .i_right(w_ent[g+1]),
                .o_entry(w_ent[g]), .o_rm_here(w_rm[g+1])
            );
        end
    endgenerate

    // boosted order: stable partition within the chain is kept only if
    // boosted users stay behind level-0 users; done by re-linking via scan
    // order in the sequencer (a boost re-inserts affected pids at the tail)
    logic [4:0] r_bpid;
    logic [CNT_W-1:0] r_bn;
    logic [IDX_W-1:0] w_pi;
    assign w_pi = r_cur[IDX_W-1:0];

    // levels are read from the per-process table, which a demotion of a
    // current process that is also queued keeps up to date
    mlfq_pkg::t_entry w_scan;
    logic [2:0] w_scan_lv;
    assign w_scan = w_ent[r_si];
    assign w_scan_lv = r_plevel[w_scan.pid[IDX_W-1:0]];

    logic [16:0] w_allot;
    logic        w_demote;
    assign w_allot  = (r_plevel[w_pi] == 3'd0) ? {1'b0, r_allot} : {r_allot, 1'b0};
    assign w_demote = r_puser[w_pi] && (r_plevel[w_pi] < LV_LAST)
                      && ({1'b0, r_pused[w_pi]} >= w_allot);

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_next_pid = r_onext;
    assign o_slice = r_oslice;
    assign o_switched = r_osw;
    assign o_status = r_ost;

    logic w_acc;
    assign w_acc = i_valid && o_ready;

    // boost pass: users at level > 0 move to the tail, in level order,
    // walking the chain once per level (r_bpid holds current level)
    logic [IDX_W-1:0] r_bi;
    mlfq_pkg::t_entry w_bent;
    logic [2:0] w_bent_lv;
    assign w_bent = w_ent[r_bi];
    assign w_bent_lv = r_plevel[w_bent.pid[IDX_W-1:0]];
    logic w_bmove;
    assign w_bmove = w_bent.valid && w_bent.is_user && (w_bent_lv == r_bpid[2:0])
                     && (r_bpid[2:0] != 3'd0) && (CNT_W'(r_bi) < r_bn);

    // status of the accepted word
    always_comb begin
        w_ost = mlfq_pkg::ST_OK;
        priority case (i_func)
            mlfq_pkg::FUNC_RESCHED:
                if (r_defer != 8'd0) w_ost = mlfq_pkg::ST_DEFERRED;
            mlfq_pkg::FUNC_ADMIT:
                if (32'(i_pid) >= NPROCS) w_ost = mlfq_pkg::ST_ERROR;
            mlfq_pkg::FUNC_CHARGE:
                w_ost = mlfq_pkg::ST_OK;
            mlfq_pkg::FUNC_DEFER_ON:
                if (r_defer == mlfq_pkg::DEFER_MAX) w_ost = mlfq_pkg::ST_ERROR;
            mlfq_pkg::FUNC_DEFER_OFF:
                if (r_defer == 8'd0) w_ost = mlfq_pkg::ST_ERROR;
            default:
                w_ost = mlfq_pkg::ST_ERROR;
        endcase
    end

    always_comb begin
        w_cmd = '0;
        w_load_en = 1'b0;
        w_load = '0;
        w_load_at = r_cnt;
        if (r_state == S_IDLE && w_acc && i_func == mlfq_pkg::FUNC_ADMIT
            && 32'(i_pid) < NPROCS && i_pid != 5'd0 && !r_pq[i_pid[IDX_W-1:0]]) begin
            w_load_en = 1'b1;
            w_load = '{1'b1, i_pid, i_is_user,
                       i_fresh ? 3'd0 : r_plevel[i_pid[IDX_W-1:0]], i_sys_priority};
        end else if (r_state == S_REQ && r_run && r_cur != 5'd0 && !r_pq[w_pi]) begin
            w_load_en = 1'b1;
            w_load = '{1'b1, r_cur, r_puser[w_pi],
                       w_demote ? r_plevel[w_pi] + 3'd1 : r_plevel[w_pi], r_pprio[w_pi]};
        end else if (r_state == S_BOOST && w_bmove) begin
            w_cmd.rm_en = 1'b1;
            w_cmd.rm_pid = w_bent.pid;
            w_load_en = 1'b1;
            w_load_at = r_cnt - CNT_W'(1);
            w_load = w_bent;
            w_load.level = 3'd0;
        end else if (r_state == S_TAKE && r_sfound) begin
            w_cmd.rm_en = 1'b1;
            w_cmd.rm_pid = r_spid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_func == mlfq_pkg::FUNC_ADMIT && 32'(i_pid) < NPROCS
            && !r_pq[i_pid[IDX_W-1:0]]) begin
            r_pprio[i_pid[IDX_W-1:0]] <= i_sys_priority;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_quantum <= 8'd2;
            r_allot <= 16'd10;
            r_cur <= '0;
            r_defer <= '0;
            r_attempt <= 1'b0;
            r_cnt <= '0;
            r_ov <= 1'b0;
            for (int k = 0; k < NPROCS; k++) begin
                r_plevel[k] <= '0;
                r_pused[k] <= '0;
                r_puser[k] <= 1'b0;
                r_pq[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'b0) r_quantum <= i_cfg_data[7:0];
                else r_allot <= i_cfg_data;
            end
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_onext <= r_cur; r_oslice <= '0; r_osw <= 1'b0;
                        r_ost <= w_ost;
                        r_run <= i_current_runnable; r_boost <= i_boost;
                        priority case (i_func)
                            mlfq_pkg::FUNC_RESCHED: begin
                                if (r_defer != 8'd0) begin
                                    r_attempt <= 1'b1;
                                    r_ov <= 1'b1;
                                end else r_state <= S_REQ;
                            end
                            mlfq_pkg::FUNC_ADMIT: begin
                                if (32'(i_pid) < NPROCS && i_pid != 5'd0
                                    && !r_pq[i_pid[IDX_W-1:0]]) begin
                                    r_puser[i_pid[IDX_W-1:0]] <= i_is_user;
                                    if (i_fresh) begin
                                        r_plevel[i_pid[IDX_W-1:0]] <= '0;
                                        r_pused[i_pid[IDX_W-1:0]] <= '0;
                                    end
                                    r_pq[i_pid[IDX_W-1:0]] <= 1'b1;
                                    r_cnt <= r_cnt + CNT_W'(1);
                                end
                                r_ov <= 1'b1;
                            end
                            mlfq_pkg::FUNC_CHARGE: begin
                                if (r_cur != 5'd0 && r_puser[w_pi])
                                    r_pused[w_pi] <= (17'(r_pused[w_pi]) + 17'(i_elapsed)
                                        > 17'hFFFF) ? 16'hFFFF : r_pused[w_pi] + i_elapsed;
                                r_ov <= 1'b1;
                            end
                            mlfq_pkg::FUNC_DEFER_ON: begin
                                if (r_defer != mlfq_pkg::DEFER_MAX) begin
                                    if (r_defer == 8'd0) r_attempt <= 1'b0;
                                    r_defer <= r_defer + 8'd1;
                                end
                                r_ov <= 1'b1;
                            end
                            mlfq_pkg::FUNC_DEFER_OFF: begin
                                if (r_defer == 8'd0) begin
                                    r_ov <= 1'b1;
                                end else begin
                                    r_defer <= r_defer - 8'd1;
                                    if (r_defer == 8'd1 && r_attempt) r_state <= S_REQ;
                                    else r_ov <= 1'b1;
                                end
                            end
                            default: begin
                                r_ov <= 1'b1;
                            end
                        endcase
                    end
                end
                S_REQ: begin
                    if (r_run && r_cur != 5'd0) begin
                        if (w_demote) begin
                            r_plevel[w_pi] <= r_plevel[w_pi] + 3'd1;
                            r_pused[w_pi] <= '0;
                        end
                        if (!r_pq[w_pi]) begin
                            r_pq[w_pi] <= 1'b1;
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                    r_bi <= '0; r_bpid <= 5'd1;
                    r_bn <= (r_run && r_cur != 5'd0 && !r_pq[w_pi]) ? r_cnt + CNT_W'(1)
                                                                      : r_cnt;
                    r_si <= '0;
                    r_sfound <= 1'b0; r_sbest <= '0; r_ubest <= LV_NONE; r_kfound <= 1'b0;
                    r_state <= r_boost ? S_BOOST : S_SCAN;
                end
                S_BOOST: begin
                    // walk the original entries once per level; moved ones
                    // shift left, so the index stays on a move
                    if (w_bmove) begin
                        r_plevel[w_bent.pid[IDX_W-1:0]] <= '0;
                        r_pused[w_bent.pid[IDX_W-1:0]] <= '0;
                        r_bn <= r_bn - CNT_W'(1);
                    end else if (CNT_W'(r_bi) + CNT_W'(1) < r_bn) begin
                        r_bi <= r_bi + IDX_W'(1);
                    end else if (r_bpid[2:0] < LV_LAST) begin
                        r_bpid <= r_bpid + 5'd1;
                        r_bi <= '0;
                    end else r_state <= S_SCAN;
                    if (!w_bmove && !(CNT_W'(r_bi) + CNT_W'(1) < r_bn)
                        && r_bpid[2:0] < LV_LAST) begin
                        r_bn <= r_cnt;
                    end
                end
                S_SCAN: begin
                    if (w_scan.valid) begin
                        if (!w_scan.is_user && w_scan.prio != '0
                            && (!r_sfound || w_scan.prio > r_sbest)) begin
                            r_sfound <= 1'b1; r_sbest <= w_scan.prio;
                            r_spid <= w_scan.pid;
                        end
                        if (w_scan.is_user && w_scan_lv < r_ubest) begin
                            r_ubest <= w_scan_lv; r_upid <= w_scan.pid;
                        end
                        if (!w_scan.is_user && !r_kfound) begin
                            r_kfound <= 1'b1; r_kpid <= w_scan.pid;
                        end
                    end
                    if (32'(r_si) == NPROCS - 1) r_state <= S_TAKE;
                    else r_si <= r_si + IDX_W'(1);
                end
                S_TAKE: begin
                    if (!r_sfound) begin
                        // fold the user and key-zero choices into the pick
                        if (r_ubest != LV_NONE) begin
                            r_sfound <= 1'b1; r_spid <= r_upid;
                            r_oslice <= 16'(r_quantum) << r_ubest;
                        end else if (r_kfound) begin
                            r_sfound <= 1'b1; r_spid <= r_kpid;
                            r_oslice <= 16'(r_quantum);
                        end else begin
                            r_onext <= '0; r_cur <= '0;
                            r_oslice <= 16'(r_quantum);
                            r_osw <= (r_cur != 5'd0);
                            r_ov <= 1'b1; r_state <= S_IDLE;
                        end
                        r_ubest <= LV_NONE; r_kfound <= 1'b0;
                    end else begin
                        if (r_ubest != LV_NONE || r_kfound) r_oslice <= 16'(r_quantum);
                        r_pq[r_spid[IDX_W-1:0]] <= 1'b0;
                        r_cnt <= r_cnt - CNT_W'(1);
                        r_onext <= r_spid; r_cur <= r_spid;
                        r_osw <= (r_spid != r_cur);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ov <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_onext)))
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("accept during work");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= NPROCS)
        else $error("queue count overflow");
endmodule

@@ src/mlfq_cell.sv @@
// one queue slot of the ready list chain
module mlfq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlfq_pkg::t_cell_cmd i_cmd,
    input  logic               i_load,
    input  mlfq_pkg::t_entry   i_load_entry,
    input  logic               i_rm_left,
    input  mlfq_pkg::t_entry   i_right,
    output mlfq_pkg::t_entry   o_entry,
    output logic               o_rm_here
);
    mlfq_pkg::t_entry r_entry, n_entry;
    logic w_hit;

    // removal point propagates: this cell or any one before it matched
    assign w_hit     = i_cmd.rm_en && r_entry.valid && (r_entry.pid == i_cmd.rm_pid);
    assign o_rm_here = i_rm_left || w_hit;
    assign o_entry   = r_entry;

    // a load at the tail wins over the shift of a removal in the same cycle
    always_comb begin
        n_entry = r_entry;
        if (i_load) begin
            n_entry = i_load_entry;
        end else if (i_cmd.rm_en && o_rm_here) begin
            n_entry = i_right;
        end else if (i_cmd.boost && r_entry.is_user) begin
            n_entry.level = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.pid     <= n_entry.pid;
        r_entry.is_user <= n_entry.is_user;
        r_entry.level   <= n_entry.level;
        r_entry.prio    <= n_entry.prio;
    end
endmodule

@@ tb/mlfq_checker.sv @@
// checker for the scheduler: predicts each result word and compares it with the output
`timescale 1ns / 100ps

module mlfq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_pid,
    input  logic        i_is_user,
    input  logic        i_fresh,
    input  logic [14:0] i_sys_priority,
    input  logic        i_current_runnable,
    input  logic        i_boost,
    input  logic [15:0] i_elapsed,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [4:0]  i_next_pid,
    input  logic [15:0] i_slice,
    input  logic        i_switched,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_seen
);

    localparam int NP = 32;
    localparam int NLEV = 5;

    typedef struct packed {
        logic [4:0]  next_pid;
        logic [15:0] slice;
        logic        switched;
        logic [1:0]  status;
    } t_sched_word;

    // predictor state
    logic [7:0]  quantum_r;
    logic [15:0] allot_r;
    logic [4:0]  cur_pid;
    logic [2:0]  lvl [NP];
    logic [15:0] used [NP];
    logic        user_f [NP];
    logic [14:0] key [NP];
    logic        in_q [NP];
    logic [4:0]  order_q [$];
    int          defer_cnt;
    logic        attempt;
    t_sched_word expected_words [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic void push_pid(input logic [4:0] p);
        if (p == 0 || in_q[p]) return;
        order_q.push_back(p);
        in_q[p] = 1'b1;
    endfunction

    // boost: system entries first, then users by level, order kept
    function automatic void boost_queue();
        logic [4:0] tmp [$];
        tmp = {};
        foreach (order_q[i]) if (!user_f[order_q[i]]) tmp.push_back(order_q[i]);
        for (int lv = 0; lv < NLEV; lv++)
            foreach (order_q[i])
                if (user_f[order_q[i]] && lvl[order_q[i]] == lv) begin
                    tmp.push_back(order_q[i]);
                    if (lv != 0) begin
                        lvl[order_q[i]] = 0;
                        used[order_q[i]] = 0;
                    end
                end
        order_q = tmp;
    endfunction

    function automatic void pick_next(input logic runnable, input logic bst,
                                      inout t_sched_word w);
        logic [4:0]  old;
        logic [16:0] allowance;
        int          best, pick, bestlv;
        logic        found;
        logic [15:0] slc;
        old = cur_pid;
        found = 0;
        best = 0;
        pick = 0;
        bestlv = NLEV;
        slc = {8'd0, quantum_r};
        if (runnable && old != 0) begin
            if (user_f[old]) begin
                allowance = (lvl[old] == 0) ? {1'b0, allot_r} : {allot_r, 1'b0};
                if (lvl[old] + 1 < NLEV && {1'b0, used[old]} >= allowance) begin
                    lvl[old] = lvl[old] + 1;
                    used[old] = 0;
                end
            end
            push_pid(old);
        end
        if (bst) boost_queue();
        foreach (order_q[i])
            if (!user_f[order_q[i]] && key[order_q[i]] != 0 &&
                (!found || key[order_q[i]] > best)) begin
                found = 1;
                best = key[order_q[i]];
                pick = i;
            end
        if (!found) begin
            foreach (order_q[i])
                if (user_f[order_q[i]] && lvl[order_q[i]] < bestlv) begin
                    bestlv = lvl[order_q[i]];
                    pick = i;
                    found = 1;
                end
            if (found) slc = 16'(quantum_r) << bestlv;
        end
        if (!found)
            foreach (order_q[i])
                if (!found && !user_f[order_q[i]]) begin
                    pick = i;
                    found = 1;
                end
        if (found) begin
            cur_pid = order_q[pick];
            order_q.delete(pick);
            in_q[cur_pid] = 0;
        end else begin
            cur_pid = 0;
        end
        w.next_pid = cur_pid;
        w.slice = slc;
        w.switched = (cur_pid != old);
        w.status = mlfq_pkg::ST_OK;
    endfunction

    function automatic t_sched_word predict_word();
        t_sched_word w;
        int t;
        w = '{next_pid: cur_pid, slice: 0, switched: 0, status: mlfq_pkg::ST_OK};
        case (i_func)
            mlfq_pkg::FUNC_RESCHED: begin
                if (defer_cnt > 0) begin
                    attempt = 1;
                    w.status = mlfq_pkg::ST_DEFERRED;
                end else pick_next(i_current_runnable, i_boost, w);
            end
            mlfq_pkg::FUNC_ADMIT: begin
                if (i_pid != 0 && !in_q[i_pid]) begin
                    user_f[i_pid] = i_is_user;
                    key[i_pid] = i_sys_priority;
                    if (i_fresh) begin
                        lvl[i_pid] = 0;
                        used[i_pid] = 0;
                    end
                    push_pid(i_pid);
                end
            end
            mlfq_pkg::FUNC_CHARGE: begin
                if (cur_pid != 0 && user_f[cur_pid]) begin
                    t = used[cur_pid] + i_elapsed;
                    used[cur_pid] = (t > 65535) ? 16'hFFFF : 16'(t);
                end
            end
            mlfq_pkg::FUNC_DEFER_ON: begin
                if (defer_cnt >= mlfq_pkg::DEFER_MAX) w.status = mlfq_pkg::ST_ERROR;
                else begin
                    if (defer_cnt == 0) attempt = 0;
                    defer_cnt++;
                end
            end
            mlfq_pkg::FUNC_DEFER_OFF: begin
                if (defer_cnt == 0) w.status = mlfq_pkg::ST_ERROR;
                else begin
                    defer_cnt--;
                    if (defer_cnt == 0 && attempt)
                        pick_next(i_current_runnable, i_boost, w);
                end
            end
            default: w.status = mlfq_pkg::ST_ERROR;
        endcase
        return w;
    endfunction

    assign o_pending = expected_words.size();

    // watch register writes, input words and output words
    always @(posedge i_clk) begin
        t_sched_word want;
        if (!i_rst_n) begin
            quantum_r <= 8'd2;
            allot_r <= 16'd10;
            cur_pid = 0;
            for (int i = 0; i < NP; i++) begin
                lvl[i] = 0;
                used[i] = 0;
                user_f[i] = 0;
                key[i] = 0;
                in_q[i] = 0;
            end
            order_q = {};
            defer_cnt = 0;
            attempt = 0;
            expected_words = {};
            o_fail_count = 0;
            o_words_seen = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'b0) quantum_r <= i_cfg_data[7:0];
                else allot_r <= i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                o_words_seen++;
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, next_pid", i_next_pid, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_next_pid !== want.next_pid)
                        report_mismatch("next_pid", i_next_pid, want.next_pid);
                    if (i_slice !== want.slice)
                        report_mismatch("slice", i_slice, want.slice);
                    if (i_switched !== want.switched)
                        report_mismatch("switched", i_switched, want.switched);
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                end
            end
            if (i_valid && i_in_ready) expected_words.push_back(predict_word());
        end
    end

endmodule

@@ tb/testbench.sv @@
// testbench top: stimulus for the scheduler, verdict from the checker
`timescale 1ns / 100ps

module testbench;

    logic        clk;
    logic        rst_n;
    logic        in_valid, in_ready;
    logic [2:0]  func;
    logic [4:0]  pid;
    logic        is_user, fresh, runnable, boost;
    logic [14:0] sys_prio;
    logic [15:0] elapsed;
    logic        out_valid, out_ready;
    logic [4:0]  next_pid;
    logic [15:0] slice;
    logic        switched;
    logic [1:0]  status;
    logic        cfg_we, cfg_idx;
    logic [15:0] cfg_data;
    int          fail_count, pending, words_seen;
    int          cycles;
    int          quiet_lo, quiet_hi;
    int          n_items;

    mlfq_process_scheduler_top uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_func(func), .i_pid(pid), .i_is_user(is_user), .i_fresh(fresh),
        .i_sys_priority(sys_prio), .i_current_runnable(runnable),
        .i_boost(boost), .i_elapsed(elapsed),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_next_pid(next_pid), .o_slice(slice), .o_switched(switched),
        .o_status(status),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    mlfq_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_func(func), .i_pid(pid), .i_is_user(is_user), .i_fresh(fresh),
        .i_sys_priority(sys_prio), .i_current_runnable(runnable),
        .i_boost(boost), .i_elapsed(elapsed),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_next_pid(next_pid), .i_slice(slice), .i_switched(switched),
        .i_status(status),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_words_seen(words_seen)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 5000000) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // output stall, none inside the quiet window
    always @(posedge clk) begin
        if (n_items >= quiet_lo && n_items < quiet_hi) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(99) >= 19);
    end

    task automatic send_word(input logic [2:0] f, input logic [4:0] p, input logic u,
                             input logic fr, input logic [14:0] k, input logic rn,
                             input logic b, input logic [15:0] e);
        while (!(n_items >= quiet_lo && n_items < quiet_hi) && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func <= f; pid <= p; is_user <= u; fresh <= fr; sys_prio <= k;
        runnable <= rn; boost <= b; elapsed <= e;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        n_items++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] v);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
        @(posedge clk);
    endtask

    // random word, mostly admits, charges and reschedules
    task automatic send_random();
        int r;
        logic [2:0] f;
        r = $urandom_range(99);
        if (r < 30) f = mlfq_pkg::FUNC_ADMIT;
        else if (r < 50) f = mlfq_pkg::FUNC_CHARGE;
        else if (r < 85) f = mlfq_pkg::FUNC_RESCHED;
        else if (r < 91) f = mlfq_pkg::FUNC_DEFER_ON;
        else if (r < 98) f = mlfq_pkg::FUNC_DEFER_OFF;
        else f = 3'($urandom_range(7, 5));
        send_word(f, 5'($urandom), 1'($urandom), 1'($urandom),
                  ($urandom_range(3) == 0) ? 15'd0 : 15'($urandom),
                  1'($urandom), ($urandom_range(9) == 0),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)));
    endtask

    initial begin
        int phase;
        rst_n = 0; in_valid = 0; out_ready = 0; cfg_we = 0; cfg_idx = 0; cfg_data = 0;
        func = 0; pid = 0; is_user = 0; fresh = 0; sys_prio = 0; runnable = 0;
        boost = 0; elapsed = 0; n_items = 0;
        quiet_lo = 700; quiet_hi = 950;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: null, keys, duplicates, demotion, boost, deferral, bad codes
        send_word(mlfq_pkg::FUNC_RESCHED, 0, 0, 0, 0, 1, 0, 0);
        send_word(mlfq_pkg::FUNC_ADMIT, 0, 1, 1, 0, 0, 0, 0);
        send_word(mlfq_pkg::FUNC_ADMIT, 5, 0, 0, 15'd0, 0, 0, 0);
        send_word(mlfq_pkg::FUNC_ADMIT, 31, 1, 1, 15'h7FFF, 0, 0, 0);
        send_word(mlfq_pkg::FUNC_ADMIT, 31, 0, 1, 15'h7FFF, 0, 0, 0);
        send_word(mlfq_pkg::FUNC_RESCHED, 0, 0, 0, 0, 0, 0, 0);
        send_word(mlfq_pkg::FUNC_CHARGE, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        send_word(mlfq_pkg::FUNC_CHARGE, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        send_word(mlfq_pkg::FUNC_RESCHED, 0, 0, 0, 0, 1, 0, 0);
        send_word(mlfq_pkg::FUNC_ADMIT, 7, 0, 0, 15'h7FFF, 0, 0, 0);
        send_word(mlfq_pkg::FUNC_RESCHED, 0, 0, 0, 0, 1, 1, 0);
        send_word(mlfq_pkg::FUNC_RESCHED, 0, 0, 0, 0, 1, 0, 0);
        send_word(mlfq_pkg::FUNC_DEFER_OFF, 0, 0, 0, 0, 0, 0, 0);
        send_word(mlfq_pkg::FUNC_DEFER_ON, 0, 0, 0, 0, 0, 0, 0);
        send_word(mlfq_pkg::FUNC_RESCHED, 0, 0, 0, 0, 1, 0, 0);
        send_word(mlfq_pkg::FUNC_DEFER_OFF, 0, 0, 0, 0, 1, 1, 0);
        send_word(3'd5, 0, 0, 0, 0, 0, 0, 0);
        send_word(3'd7, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 256; i++)
            send_word(mlfq_pkg::FUNC_DEFER_ON, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 256; i++)
            send_word(mlfq_pkg::FUNC_DEFER_OFF, 0, 0, 0, 0, 1, 0, 0);
        wait_drain();

        // random phases over several register settings
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(0, 16'd1); write_reg(1, 16'd1); end
                1: begin write_reg(0, 16'd255); write_reg(1, 16'hFFFF); end
                2: begin write_reg(0, 16'd3); write_reg(1, 16'd20); end
                3: begin write_reg(0, 16'd128); write_reg(1, 16'h8000); end
                default: begin write_reg(0, 16'd2); write_reg(1, 16'd10); end
            endcase
            cfg_we <= 1'b0;
            for (int i = 0; i < 275; i++) send_random();
            wait_drain();
        end

        $display("ran %0d words over five register settings, %0d results checked",
                 n_items, words_seen);
        $display("covered admits, charges, demotion, boost, deferral and error codes");
        if (fail_count == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/mlfq_pkg.sv
src/mlfq_cell.sv
src/mlfq_process_scheduler_top.sv
tb/mlfq_checker.sv
tb/testbench.sv
